@@ src/rgbconv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbconv_pkg: shared types and constants
// Widths, register map, reset values and pipeline payload types of the
// streaming 3x3 RGB convolution.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 8;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int TAP_W   = 16;
	localparam int KROW_W  = 3 * TAP_W;
	localparam int IMG_W_W = 11;
	localparam int IMG_H_W = 13;
	localparam int ROW_W   = 13;
	localparam int PROD_W  = 24;
	localparam int SUM_W   = 28;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;

	localparam logic [ROW_W-1:0]   HEIGHT_LIMIT = ROW_W'(4096);
	localparam logic [CH_W-1:0]    PIX_MAX      = CH_W'(255);
	localparam logic [IMG_W_W-1:0] DEF_WIDTH    = IMG_W_W'(640);
	localparam logic [IMG_H_W-1:0] DEF_HEIGHT   = IMG_H_W'(480);
	localparam logic [KROW_W-1:0]  DEF_KMID     = KROW_W'(48'h0000_0100_0000);

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KTOP   = 3'd2,
		REG_KMID   = 3'd3,
		REG_KBOT   = 3'd4
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0] win_t;
	typedef logic [2:0][KROW_W-1:0] kernel_t;

	typedef struct packed {
		pix_t pixel;
		pix_t top;
		pix_t mid;
		logic at_left;
		logic produce;
		logic top_ok;
		logic bot_ok;
		logic frame_end;
	} col_req_t;

	typedef struct packed {
		win_t pix;
		logic frame_end;
	} mac_req_t;

endpackage

@@ src/rgbconv_if.sv @@
// ----------------------------------------------------------------------------
// rgbconv_if: pixel stream channels
// Valid/ready channels for input pixels and filtered output pixels.
// ----------------------------------------------------------------------------
interface rgbconv_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [rgbconv_pkg::CH_W-1:0] in_red;
	logic [rgbconv_pkg::CH_W-1:0] in_green;
	logic [rgbconv_pkg::CH_W-1:0] in_blue;

	modport source (output valid, mode, in_red, in_green, in_blue, input ready);
	modport sink (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface rgbconv_out_if;
	logic valid;
	logic ready;
	logic [rgbconv_pkg::CH_W-1:0] out_red;
	logic [rgbconv_pkg::CH_W-1:0] out_green;
	logic [rgbconv_pkg::CH_W-1:0] out_blue;
	logic frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

@@ src/rgbconv_cfg.sv @@
// ----------------------------------------------------------------------------
// rgbconv_cfg: configuration registers
// APB-style register bank for frame geometry and the three kernel rows.
// ----------------------------------------------------------------------------
module rgbconv_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rgbconv_pkg::ADDR_W-1:0] paddr,
	input  logic [rgbconv_pkg::DATA_W-1:0] pwdata,
	output logic [rgbconv_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [rgbconv_pkg::IMG_W_W-1:0] image_width,
	output logic [rgbconv_pkg::IMG_H_W-1:0] image_height,
	output rgbconv_pkg::kernel_t kernel
);
	import rgbconv_pkg::*;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	kernel_t kernel_q;
	reg_idx_t reg_idx;
	logic wr;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DEF_WIDTH;
			height_q <= DEF_HEIGHT;
			kernel_q[0] <= '0;
			kernel_q[1] <= DEF_KMID;
			kernel_q[2] <= '0;
		end else if (wr) begin
			unique case (reg_idx)
				REG_WIDTH: begin
					width_q <= pwdata[IMG_W_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= pwdata[IMG_H_W-1:0];
				end
				REG_KTOP: begin
					kernel_q[0] <= pwdata[KROW_W-1:0];
				end
				REG_KMID: begin
					kernel_q[1] <= pwdata[KROW_W-1:0];
				end
				REG_KBOT: begin
					kernel_q[2] <= pwdata[KROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_KTOP:   prdata = DATA_W'(kernel_q[0]);
			REG_KMID:   prdata = DATA_W'(kernel_q[1]);
			REG_KBOT:   prdata = DATA_W'(kernel_q[2]);
			default:    prdata = '0;
		endcase
	end

	assign image_width = width_q;
	assign image_height = height_q;
	assign kernel = kernel_q;

endmodule

@@ src/rgbconv_ctl.sv @@
// ----------------------------------------------------------------------------
// rgbconv_ctl: raster position and line store
// Tracks column and row, latches the frame geometry, reads and rewrites the
// two-line store and classifies each request for the window stage.
// ----------------------------------------------------------------------------
module rgbconv_ctl #(
	parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rgbconv_in_if.sink pix_in,
	input  logic [rgbconv_pkg::IMG_W_W-1:0] image_width,
	input  logic [rgbconv_pkg::IMG_H_W-1:0] image_height,
	output rgbconv_pkg::col_req_t s1_req,
	output logic s1_valid,
	input  logic s1_ready
);
	import rgbconv_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int FW_W  = $clog2(MAX_WIDTH + 1);

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [FW_W-1:0]  frame_w_q;
	logic [ROW_W-1:0] frame_h_q;
	logic             valid_s1;

	logic [2*PIX_W-1:0] rd_s1;
	logic [COL_W-1:0]   col_s1;
	pix_t               pixel_s1;
	logic               at_left_s1;
	logic               produce_s1;
	logic               top_ok_s1;
	logic               bot_ok_s1;
	logic               frame_end_s1;

	logic [FW_W-1:0]  w_lim;
	logic [ROW_W-1:0] h_lim;
	logic [FW_W-1:0]  fw;
	logic [ROW_W-1:0] fh;
	logic start, in_frame, ignored, at_left, produce, top_ok, bot_ok, frame_end;
	logic wrap, accept, ld;
	pix_t pixel;

	always_comb begin
		if (image_width < IMG_W_W'(2)) begin
			w_lim = FW_W'(2);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_lim = FW_W'(MAX_WIDTH);
		end else begin
			w_lim = FW_W'(image_width);
		end
		if (image_height < IMG_H_W'(2)) begin
			h_lim = ROW_W'(2);
		end else if (image_height > HEIGHT_LIMIT) begin
			h_lim = HEIGHT_LIMIT;
		end else begin
			h_lim = image_height;
		end
	end

	assign start     = (row_q == '0) && (col_q == '0);
	assign fw        = start ? w_lim : frame_w_q;
	assign fh        = start ? h_lim : frame_h_q;
	assign in_frame  = row_q < fh;
	assign ignored   = pix_in.mode && in_frame;
	assign at_left   = col_q == '0;
	assign produce   = at_left ? (row_q >= ROW_W'(2)) : (row_q >= ROW_W'(1));
	assign top_ok    = at_left ? (row_q >= ROW_W'(3)) : (row_q >= ROW_W'(2));
	assign bot_ok    = at_left ? (row_q <= fh) : (row_q < fh);
	assign frame_end = at_left && (row_q == fh + ROW_W'(1));
	assign pixel     = in_frame ? {pix_in.in_blue, pix_in.in_green, pix_in.in_red} : '0;
	assign wrap      = (FW_W'(col_q) + FW_W'(1)) >= fw;

	assign pix_in.ready = !valid_s1 || s1_ready;
	assign accept = pix_in.valid && pix_in.ready;
	assign ld = accept && !ignored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			frame_w_q <= '0;
			frame_h_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pix_in.ready) begin
				valid_s1 <= ld;
			end
			if (ld) begin
				if (start) begin
					frame_w_q <= w_lim;
					frame_h_q <= h_lim;
				end
				if (produce && frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rd_s1 <= line_mem[col_q];
			col_s1 <= col_q;
			pixel_s1 <= pixel;
			at_left_s1 <= at_left;
			produce_s1 <= produce;
			top_ok_s1 <= top_ok;
			bot_ok_s1 <= bot_ok;
			frame_end_s1 <= frame_end;
		end
		if (valid_s1 && s1_ready) begin
			line_mem[col_s1] <= {rd_s1[PIX_W-1:0], pixel_s1};
		end
	end

	assign s1_valid = valid_s1;
	assign s1_req = '{
		pixel:     pixel_s1,
		top:       rd_s1[2*PIX_W-1:PIX_W],
		mid:       rd_s1[PIX_W-1:0],
		at_left:   at_left_s1,
		produce:   produce_s1,
		top_ok:    top_ok_s1,
		bot_ok:    bot_ok_s1,
		frame_end: frame_end_s1
	};

	assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> (FW_W'(col_q) < frame_w_q))
		else $error("column beyond latched width");
	assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= frame_h_q + ROW_W'(1))
		else $error("row beyond drain limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		ld && produce && frame_end |=> start)
		else $error("frame end did not rewind position");

endmodule

@@ src/rgbconv_win.sv @@
// ----------------------------------------------------------------------------
// rgbconv_win: 3x3 neighbor window
// Shifts the new column into the window, zeroes rows outside the image and
// registers the window of each pixel that is due.
// ----------------------------------------------------------------------------
module rgbconv_win (
	input  logic clk,
	input  logic arst_n,
	input  rgbconv_pkg::col_req_t s1_req,
	input  logic s1_valid,
	output logic s1_ready,
	output rgbconv_pkg::mac_req_t s2_req,
	output logic s2_valid,
	input  logic s2_ready
);
	import rgbconv_pkg::*;

	win_t win_q;
	win_t shifted;
	win_t next_win;
	win_t emit_win;
	win_t pix_s2;
	logic frame_end_s2;
	logic valid_s2;
	logic adv;

	always_comb begin
		pix_t col [3];
		col[0] = s1_req.top;
		col[1] = s1_req.mid;
		col[2] = s1_req.pixel;
		for (int r = 0; r < 3; r++) begin
			shifted[r*3]     = win_q[r*3+1];
			shifted[r*3+1]   = win_q[r*3+2];
			shifted[r*3+2]   = s1_req.at_left ? '0 : col[r];
		end
		emit_win = shifted;
		if (!s1_req.top_ok) begin
			emit_win[0] = '0;
			emit_win[1] = '0;
			emit_win[2] = '0;
		end
		if (!s1_req.bot_ok) begin
			emit_win[6] = '0;
			emit_win[7] = '0;
			emit_win[8] = '0;
		end
		if (s1_req.produce && s1_req.frame_end) begin
			next_win = '0;
		end else if (s1_req.at_left) begin
			next_win = '0;
			next_win[2] = col[0];
			next_win[5] = col[1];
			next_win[8] = col[2];
		end else begin
			next_win = shifted;
		end
	end

	assign s1_ready = !valid_s2 || s2_ready;
	assign adv = s1_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				win_q <= next_win;
			end
			if (s1_ready) begin
				valid_s2 <= s1_valid && s1_req.produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= emit_win;
			frame_end_s2 <= s1_req.frame_end;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_req = '{pix: pix_s2, frame_end: frame_end_s2};

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && s1_req.produce && s1_req.frame_end |=> win_q == '0)
		else $error("window not cleared after frame end");

endmodule

@@ src/rgbconv_mac.sv @@
// ----------------------------------------------------------------------------
// rgbconv_mac: kernel multiply, sum and clamp
// Forms the 27 tap products, sums each channel, drops the fraction bits,
// clamps to 0..255 and holds the result in the output register.
// ----------------------------------------------------------------------------
module rgbconv_mac #(
	parameter int FRAC_BITS = rgbconv_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rgbconv_pkg::mac_req_t s2_req,
	input  logic s2_valid,
	output logic s2_ready,
	input  rgbconv_pkg::kernel_t kernel,
	rgbconv_out_if.source pix_out
);
	import rgbconv_pkg::*;

	logic signed [PROD_W-1:0] prod_c  [3][9];
	logic signed [PROD_W-1:0] prod_s3 [3][9];
	logic                     frame_end_s3;
	logic                     valid_s3;
	logic [CH_W-1:0]          chan_c [3];
	logic [CH_W-1:0]          chan_q [3];
	logic                     frame_end_q;
	logic                     out_valid_q;
	logic                     out_free;

	always_comb begin
		logic signed [PROD_W-1:0] a;
		logic signed [PROD_W-1:0] b;
		a = '0;
		b = '0;
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					a = PROD_W'($signed({1'b0, s2_req.pix[r*3+c][CH_W*ch +: CH_W]}));
					b = PROD_W'($signed(kernel[r][TAP_W*c +: TAP_W]));
					prod_c[ch][r*3+c] = a * b;
				end
			end
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] q;
		sum = '0;
		q = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum = '0;
			for (int i = 0; i < 9; i++) begin
				sum = sum + SUM_W'(prod_s3[ch][i]);
			end
			q = sum >>> FRAC_BITS;
			if (sum < 0) begin
				chan_c[ch] = '0;
			end else if (q > SUM_W'(PIX_MAX)) begin
				chan_c[ch] = PIX_MAX;
			end else begin
				chan_c[ch] = q[CH_W-1:0];
			end
		end
	end

	assign out_free = !out_valid_q || pix_out.ready;
	assign s2_ready = !valid_s3 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s3 <= s2_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid && s2_ready) begin
			prod_s3 <= prod_c;
			frame_end_s3 <= s2_req.frame_end;
		end
		if (valid_s3 && out_free) begin
			chan_q <= chan_c;
			frame_end_q <= frame_end_s3;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.out_red = chan_q[0];
	assign pix_out.out_green = chan_q[1];
	assign pix_out.out_blue = chan_q[2];
	assign pix_out.frame_end = frame_end_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s3))
		else $error("result without product stage");

endmodule

@@ src/rgb_conv3x3_zero_pad.sv @@
// ----------------------------------------------------------------------------
// rgb_conv3x3_zero_pad: streaming 3x3 RGB convolution
// Zero-padded 3x3 filter over a raster pixel stream, Q8.8 kernel taps.
//
// pix_in carries requests: mode 0 is a pixel, mode 1 a drain tick. Send the
// frame in raster order, then image_width+1 drain ticks to push out the last
// row; drain ticks before the frame is complete are taken and dropped.
// pix_out delivers filtered pixels in raster order, one row plus one pixel
// behind the input; frame_end marks the last pixel of the frame, after which
// the next pixel starts a new frame. Geometry is latched at a frame's first
// pixel; write registers only while the block is idle.
// Throughput: one request per cycle while pix_out is ready, set by the line
// store, read at acceptance and written back through its own write port as
// the request leaves the first stage. Path: the request, then its window, then
// its products are registered before a due result reaches the output register.
// Stalls: each stage holds its own valid, so requests keep entering while a
// result waits on pix_out.ready until the pipeline is full.
// Reset: arst_n clears position, window and valids; the line store is not
// cleared, its stale rows are masked as outside the image.
// ----------------------------------------------------------------------------
module rgb_conv3x3_zero_pad #(
	parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF,
	parameter int FRAC_BITS = rgbconv_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rgbconv_in_if.sink pix_in,
	rgbconv_out_if.source pix_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rgbconv_pkg::ADDR_W-1:0] paddr,
	input  logic [rgbconv_pkg::DATA_W-1:0] pwdata,
	output logic [rgbconv_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import rgbconv_pkg::*;

	logic [IMG_W_W-1:0] image_width;
	logic [IMG_H_W-1:0] image_height;
	kernel_t kernel;
	col_req_t s1_req;
	logic s1_valid;
	logic s1_ready;
	mac_req_t s2_req;
	logic s2_valid;
	logic s2_ready;

	rgbconv_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.image_width  (image_width),
		.image_height (image_height),
		.kernel       (kernel)
	);

	rgbconv_ctl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_in       (pix_in),
		.image_width  (image_width),
		.image_height (image_height),
		.s1_req       (s1_req),
		.s1_valid     (s1_valid),
		.s1_ready     (s1_ready)
	);

	rgbconv_win u_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_req   (s1_req),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s2_req   (s2_req),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready)
	);

	rgbconv_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_req   (s2_req),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.kernel   (kernel),
		.pix_out  (pix_out)
	);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: streaming 3x3 RGB convolution testbench
// Sends raster frames of RGB pixels with drain ticks, idles and stalls both
// channels at random, and compares every filtered pixel field by field with a
// behavioral filter that follows each accepted request. Geometry and kernel
// registers are rewritten between frames, sizes below the minimum and extreme
// taps included.
// ----------------------------------------------------------------------------
module tb;
	import rgbconv_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_REQUESTS = 900;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic frame_end;
	} out_pix_t;

	class rgb_filter_board;
		logic [IMG_W_W-1:0] width_reg;
		logic [IMG_H_W-1:0] height_reg;
		logic [KROW_W-1:0] krow [3];
		logic [2*PIX_W-1:0] line_store [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] win [9];
		int col, row, fw, fh;
		out_pix_t due_pixels [$];
		int mismatches;
		int pixels_checked;

		function new();
			width_reg = DEF_WIDTH;
			height_reg = DEF_HEIGHT;
			krow[0] = '0;
			krow[1] = DEF_KMID;
			krow[2] = '0;
			foreach (line_store[i]) line_store[i] = '0;
			foreach (win[i]) win[i] = '0;
			col = 0;
			row = 0;
			fw = clamp_dim(width_reg, MAX_WIDTH_DEF);
			fh = clamp_dim(height_reg, HEIGHT_LIMIT);
			mismatches = 0;
			pixels_checked = 0;
		endfunction

		function int clamp_dim(int v, int hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				REG_WIDTH: width_reg = v[IMG_W_W-1:0];
				REG_HEIGHT: height_reg = v[IMG_H_W-1:0];
				REG_KTOP: krow[0] = v[KROW_W-1:0];
				REG_KMID: krow[1] = v[KROW_W-1:0];
				REG_KBOT: krow[2] = v[KROW_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CH_W-1:0] filter_channel(int ch, bit top_ok, bit bot_ok);
			int sum;
			int q;
			logic signed [TAP_W-1:0] tap;
			logic [CH_W-1:0] pix;
			sum = 0;
			for (int i = 0; i < 9; i++) begin
				if (i / 3 == 0 && !top_ok) continue;
				if (i / 3 == 2 && !bot_ok) continue;
				pix = win[i][CH_W*ch +: CH_W];
				tap = krow[i / 3][TAP_W*(i % 3) +: TAP_W];
				sum += int'(pix) * int'(tap);
			end
			if (sum < 0) return '0;
			q = sum >>> FRAC_BITS_DEF;
			return (q > 255) ? PIX_MAX : q[CH_W-1:0];
		endfunction

		function out_pix_t filtered(int orow, int ocol);
			out_pix_t res;
			bit top_ok, bot_ok;
			top_ok = orow >= 1;
			bot_ok = orow + 1 < fh;
			res.red = filter_channel(0, top_ok, bot_ok);
			res.green = filter_channel(1, top_ok, bot_ok);
			res.blue = filter_channel(2, top_ok, bot_ok);
			res.frame_end = (orow == fh - 1) && (ocol == fw - 1);
			return res;
		endfunction

		function void shift_col(logic [PIX_W-1:0] top, mid, bot);
			for (int r = 0; r < 3; r++) begin
				win[3*r] = win[3*r+1];
				win[3*r+1] = win[3*r+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = bot;
		endfunction

		function void take_request(bit mode, logic [CH_W-1:0] r, g, b);
			logic [PIX_W-1:0] pixel, top, mid;
			logic [2*PIX_W-1:0] ent;
			int c, rr;
			bit produced;
			out_pix_t res;
			produced = 0;
			if (row == 0 && col == 0) begin
				if (mode) return;
				fw = clamp_dim(width_reg, MAX_WIDTH_DEF);
				fh = clamp_dim(height_reg, HEIGHT_LIMIT);
			end
			if (row < fh) begin
				if (mode) return;
				pixel = {b, g, r};
			end else begin
				pixel = '0;
			end
			c = (col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col;
			rr = row;
			ent = line_store[c];
			top = ent[2*PIX_W-1:PIX_W];
			mid = ent[PIX_W-1:0];
			line_store[c] = {mid, pixel};
			if (c == 0) begin
				shift_col('0, '0, '0);
				if (rr >= 2) begin
					res = filtered(rr - 2, fw - 1);
					produced = 1;
				end
				foreach (win[i]) win[i] = '0;
				win[2] = top;
				win[5] = mid;
				win[8] = pixel;
			end else begin
				shift_col(top, mid, pixel);
				if (rr >= 1) begin
					res = filtered(rr - 1, c - 1);
					produced = 1;
				end
			end
			col = c + 1;
			if (col >= fw) begin
				col = 0;
				row = rr + 1;
			end
			if (produced) begin
				due_pixels.push_back(res);
				if (res.frame_end) begin
					col = 0;
					row = 0;
					foreach (win[i]) win[i] = '0;
				end
			end
		endfunction

		task report_mismatch(string what);
			if (mismatches < 25) $display("MISMATCH at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_pixel(out_pix_t got);
			out_pix_t want;
			if (due_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %0h/%0h/%0h with nothing due",
					got.red, got.green, got.blue));
				return;
			end
			want = due_pixels.pop_front();
			pixels_checked++;
			if (got.red !== want.red)
				report_mismatch($sformatf("pixel %0d red %0d, want %0d",
					pixels_checked, got.red, want.red));
			if (got.green !== want.green)
				report_mismatch($sformatf("pixel %0d green %0d, want %0d",
					pixels_checked, got.green, want.green));
			if (got.blue !== want.blue)
				report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
					pixels_checked, got.blue, want.blue));
			if (got.frame_end !== want.frame_end)
				report_mismatch($sformatf("pixel %0d frame_end %0b, want %0b",
					pixels_checked, got.frame_end, want.frame_end));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	rgbconv_in_if pin();
	rgbconv_out_if pout();

	rgb_filter_board board;
	bit calm;
	int quiet_cycles;
	int requests_sent;
	int frames_run;

	rgb_conv3x3_zero_pad uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pin),
		.pix_out(pout),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		pout.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin : monitor
		out_pix_t got;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (pout.valid && pout.ready) begin
				got.red = pout.out_red;
				got.green = pout.out_green;
				got.blue = pout.out_blue;
				got.frame_end = pout.frame_end;
				board.check_pixel(got);
				moved = 1;
			end
			if (pin.valid && pin.ready) begin
				board.take_request(pin.mode, pin.in_red, pin.in_green, pin.in_blue);
				moved = 1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a handshake", quiet_cycles);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [CH_W-1:0] random_chan();
		case ($urandom_range(3))
			0: return '0;
			1: return PIX_MAX;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [TAP_W-1:0] random_tap();
		case ($urandom_range(4))
			0: return '0;
			1: return TAP_W'($urandom());
			2: return TAP_W'(int'($urandom_range(1200)) - 600);
			3: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return TAP_W'($urandom_range(300));
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] random_krow();
		return {random_tap(), random_tap(), random_tap()};
	endfunction

	task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(bit mode, logic [CH_W-1:0] r, g, b);
		while (!calm && $urandom_range(99) < 27) begin
			pin.valid <= 1'b0;
			@(posedge clk);
		end
		pin.valid <= 1'b1;
		pin.mode <= mode;
		pin.in_red <= r;
		pin.in_green <= g;
		pin.in_blue <= b;
		do @(posedge clk); while (!pin.ready);
		requests_sent++;
	endtask

	task automatic settle();
		pin.valid <= 1'b0;
		@(posedge clk);
		while (board.due_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_frame(int w_reg, int h_reg);
		int w, h;
		settle();
		cfg_write(REG_WIDTH, DATA_W'(w_reg));
		cfg_write(REG_HEIGHT, DATA_W'(h_reg));
		if ($urandom_range(3) != 0) cfg_write(REG_KTOP, DATA_W'(random_krow()));
		if ($urandom_range(3) != 0) cfg_write(REG_KMID, DATA_W'(random_krow()));
		if ($urandom_range(3) != 0) cfg_write(REG_KBOT, DATA_W'(random_krow()));
		w = board.clamp_dim(w_reg, MAX_WIDTH_DEF);
		h = board.clamp_dim(h_reg, HEIGHT_LIMIT);
		if ($urandom_range(3) == 0)
			send_request(1'b1, random_chan(), random_chan(), random_chan());
		for (int p = 0; p < w * h; p++) begin
			if ($urandom_range(19) == 0)
				send_request(1'b1, random_chan(), random_chan(), random_chan());
			send_request(1'b0, random_chan(), random_chan(), random_chan());
		end
		for (int d = 0; d <= w; d++)
			send_request(1'($urandom_range(1)), random_chan(), random_chan(), random_chan());
		frames_run++;
	endtask

	initial begin
		int w_reg, h_reg;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		quiet_cycles = 0;
		requests_sent = 0;
		frames_run = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pin.valid = 1'b0;
		pin.mode = 1'b0;
		pin.in_red = '0;
		pin.in_green = '0;
		pin.in_blue = '0;
		pout.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset kernel (identity), drains before and inside the frame, pixels as drains
		cfg_write(REG_WIDTH, DATA_W'(3));
		cfg_write(REG_HEIGHT, DATA_W'(2));
		send_request(1'b1, 8'hff, 8'h00, 8'hff);
		send_request(1'b1, 8'h00, 8'hff, 8'h00);
		send_request(1'b0, 8'hff, 8'hff, 8'hff);
		send_request(1'b0, 8'h00, 8'h00, 8'h00);
		send_request(1'b0, 8'hff, 8'h00, 8'h80);
		send_request(1'b1, 8'h55, 8'haa, 8'h55);
		send_request(1'b0, 8'h01, 8'h02, 8'h04);
		send_request(1'b0, 8'h80, 8'h40, 8'h20);
		send_request(1'b0, 8'haa, 8'h55, 8'hff);
		send_request(1'b0, 8'hff, 8'hff, 8'hff);
		send_request(1'b0, 8'h11, 8'h22, 8'h33);
		send_request(1'b1, 8'h00, 8'h00, 8'h00);
		send_request(1'b1, 8'hff, 8'hff, 8'hff);
		frames_run++;
		settle();

		// extreme taps, geometry below the minimum
		cfg_write(REG_WIDTH, DATA_W'(1));
		cfg_write(REG_HEIGHT, DATA_W'(1));
		cfg_write(REG_KTOP, DATA_W'(48'h8000_7fff_8000));
		cfg_write(REG_KMID, DATA_W'(48'hffff_0001_7fff));
		cfg_write(REG_KBOT, DATA_W'(48'h7fff_8000_0100));
		send_request(1'b0, 8'hff, 8'hff, 8'hff);
		send_request(1'b0, 8'h00, 8'h80, 8'hff);
		send_request(1'b0, 8'hff, 8'h00, 8'h01);
		send_request(1'b0, 8'h55, 8'haa, 8'hf0);
		send_request(1'b1, 8'h00, 8'h00, 8'h00);
		send_request(1'b0, 8'h7f, 8'hfe, 8'h0f);
		send_request(1'b1, 8'h00, 8'h00, 8'h00);
		frames_run++;

		while (requests_sent < RANDOM_REQUESTS) begin
			calm = (frames_run >= 8 && frames_run < 12);
			if ($urandom_range(7) == 0) begin
				w_reg = $urandom_range(60, 20);
				h_reg = $urandom_range(4, 0);
			end else begin
				w_reg = $urandom_range(14);
				h_reg = $urandom_range(9);
			end
			run_frame(w_reg, h_reg);
		end
		calm = 1'b0;

		run_frame($urandom_range(6, 2), $urandom_range(5, 2));

		settle();
		if (board.due_pixels.size() != 0)
			board.report_mismatch($sformatf("%0d filtered pixels never arrived",
				board.due_pixels.size()));
		$display("covered %0d frames from 2x2 to 60 wide, undersized geometry and random taps,",
			frames_run);
		$display("  %0d requests accepted, %0d filtered pixels checked, %0d mismatches",
			requests_sent, board.pixels_checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

@@ sim.f @@
src/rgbconv_pkg.sv
src/rgbconv_if.sv
src/rgbconv_cfg.sv
src/rgbconv_ctl.sv
src/rgbconv_win.sv
src/rgbconv_mac.sv
src/rgb_conv3x3_zero_pad.sv
dv/tb.sv
